>>> hdl/ncp_pkg.sv
// Shared types and constants for the narrow channel packer.
`default_nettype none
package ncp_pkg;

    localparam int BPC_W   = 4;
    localparam int ACC_W   = 7;
    localparam int FILL_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;

    localparam logic [BPC_W-1:0] BPC_RESET = 4'd7;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_CODED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXTRA = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNSUP = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OVFL  = 2'd3;

    // output queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [KIND_W-1:0] kind;
        logic              unchanged;
        logic              last_out;
    } ncp_result_t;

endpackage : ncp_pkg
`default_nettype wire

>>> hdl/ncp_extra_mem.sv
// Extra character store: one write port, one read port, registered read data.
`default_nettype none
module ncp_extra_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [AW-1:0]            wr_addr,
    input  wire logic [ncp_pkg::ACC_W-1:0] wr_data,
    input  wire logic                     rd_en,
    input  wire logic [AW-1:0]            rd_addr,
    output logic      [ncp_pkg::ACC_W-1:0] rd_data
);
    import ncp_pkg::*;

    logic [ACC_W-1:0] store_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= store_mem[rd_addr];
        end
    end

endmodule : ncp_extra_mem
`default_nettype wire

>>> hdl/ncp_out_fifo.sv
// Small output queue decoupling the coder from the result stream.
`default_nettype none
module ncp_out_fifo (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire ncp_pkg::ncp_result_t     push_data,
    input  wire logic                     pop_ready,
    output logic                          pop_valid,
    output ncp_pkg::ncp_result_t          pop_data,
    output logic      [ncp_pkg::OQ_CW-1:0] count
);
    import ncp_pkg::*;

    ncp_result_t       entry_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]  wr_ptr_reg;
    logic [OQ_AW-1:0]  rd_ptr_reg;
    logic [OQ_CW-1:0]  count_reg;
    logic [OQ_CW-1:0]  count_next;
    logic              pop;

    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;
    assign count     = count_reg;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + OQ_CW'(1);
            2'b01:   count_next = count_reg - OQ_CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OQ_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OQ_AW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule : ncp_out_fifo
`default_nettype wire

>>> hdl/ncp_coder.sv
// Coder: block state, high-bit grouping, extra store access and drain sequencer.
`default_nettype none
module ncp_coder #(
    parameter int MAX_BLOCK = 32,
    parameter int AW        = 5,
    parameter int CW        = 6
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [ncp_pkg::BPC_W-1:0]  cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [ncp_pkg::BYTE_W-1:0] in_data,
    input  wire logic                       in_last,
    input  wire logic [ncp_pkg::OQ_CW-1:0]  fifo_count,
    output logic                            push,
    output ncp_pkg::ncp_result_t            push_data,
    output logic                            mem_wr_en,
    output logic      [AW-1:0]              mem_wr_addr,
    output logic      [ncp_pkg::ACC_W-1:0]  mem_wr_data,
    output logic                            mem_rd_en,
    output logic      [AW-1:0]              mem_rd_addr,
    input  wire logic [ncp_pkg::ACC_W-1:0]  mem_rd_data
);
    import ncp_pkg::*;

    localparam logic [0:0]    ST_IDLE  = 1'b0;
    localparam logic [0:0]    ST_DRAIN = 1'b1;
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_BLOCK);

    logic [0:0]        state_reg;
    logic [BPC_W-1:0]  bpc_reg;
    logic [ACC_W-1:0]  group_accum_reg;
    logic [FILL_W-1:0] group_fill_reg;
    logic [CW-1:0]     extra_count_reg;
    logic [CW-1:0]     byte_count_reg;
    logic              any_high_reg;
    logic [CW-1:0]     drain_total_reg;
    logic [CW-1:0]     rd_idx_reg;
    logic              rd_pending_reg;
    logic              rd_last_reg;

    logic              idle;
    logic              room;
    logic              accept;
    logic              mode_pass;
    logic              mode_code;
    logic [1:0]        n_sel;
    logic [3:0]        hi;
    logic [BYTE_W-1:0] lo;
    logic [FILL_W-1:0] cost;
    logic [ACC_W-1:0]  acc_shift;
    logic              ovfl;
    logic              coded;
    logic [FILL_W-1:0] fill_inc;
    logic              grp_done;
    logic [ACC_W-1:0]  eff_acc;
    logic [FILL_W-1:0] eff_fill;
    logic              eff_any;
    logic              store;
    logic              store_ok;
    logic [CW-1:0]     ext_new;
    logic              drain;
    logic              issue;
    logic              issue_last;
    ncp_result_t       in_res;
    ncp_result_t       rd_res;

    assign idle      = (state_reg == ST_IDLE);
    assign room      = ((fifo_count + OQ_CW'(rd_pending_reg)) < OQ_CW'(OQ_DEPTH));
    assign cfg_ready = idle && !rd_pending_reg;
    assign in_ready  = idle && !rd_pending_reg && room && !cfg_valid;
    assign accept    = in_valid && in_ready;

    assign mode_pass = bpc_reg[3];
    assign mode_code = (bpc_reg[3:2] == 2'b01);
    assign n_sel     = bpc_reg[1:0];

    // N = 4..7 selects M = 4..1 high bits and group cost 1,1,3,7
    always_comb
    begin
        unique case (n_sel)
            2'd0:
            begin
                hi        = in_data[7:4];
                lo        = {4'b0, in_data[3:0]};
                cost      = 3'd1;
                acc_shift = {group_accum_reg[2:0], in_data[7:4]};
            end
            2'd1:
            begin
                hi        = {1'b0, in_data[7:5]};
                lo        = {3'b0, in_data[4:0]};
                cost      = 3'd1;
                acc_shift = {group_accum_reg[3:0], in_data[7:5]};
            end
            2'd2:
            begin
                hi        = {2'b0, in_data[7:6]};
                lo        = {2'b0, in_data[5:0]};
                cost      = 3'd3;
                acc_shift = {group_accum_reg[4:0], in_data[7:6]};
            end
            default:
            begin
                hi        = {3'b0, in_data[7]};
                lo        = {1'b0, in_data[6:0]};
                cost      = 3'd7;
                acc_shift = {group_accum_reg[5:0], in_data[7]};
            end
        endcase
    end

    assign ovfl     = (byte_count_reg >= MAX_CNT);
    assign coded    = mode_code && !ovfl;
    assign fill_inc = group_fill_reg + FILL_W'(1);
    assign grp_done = coded && (fill_inc >= cost);
    assign eff_acc  = coded ? acc_shift : group_accum_reg;
    assign eff_fill = coded ? fill_inc : group_fill_reg;
    assign eff_any  = any_high_reg || (coded && (hi != 4'd0));
    // a full group, or the partial group left at end of block
    assign store    = mode_code && (grp_done || (in_last && (eff_fill != '0)));
    assign store_ok = store && (extra_count_reg < MAX_CNT);
    assign ext_new  = extra_count_reg + CW'(store_ok);
    assign drain    = mode_code && in_last && eff_any;

    assign mem_wr_en   = accept && store_ok;
    assign mem_wr_addr = extra_count_reg[AW-1:0];
    assign mem_wr_data = eff_acc;

    always_comb
    begin
        priority if (mode_pass)
        begin
            in_res = '{out_byte: in_data, kind: KIND_CODED,
                       unchanged: in_last, last_out: in_last};
        end
        else if (!mode_code)
        begin
            in_res = '{out_byte: '0, kind: KIND_UNSUP,
                       unchanged: 1'b0, last_out: in_last};
        end
        else if (ovfl)
        begin
            in_res = '{out_byte: '0, kind: KIND_OVFL,
                       unchanged: in_last && !eff_any, last_out: in_last && !eff_any};
        end
        else
        begin
            in_res = '{out_byte: lo, kind: KIND_CODED,
                       unchanged: in_last && !eff_any, last_out: in_last && !eff_any};
        end
    end

    assign rd_res = '{out_byte: {1'b0, mem_rd_data}, kind: KIND_EXTRA,
                      unchanged: 1'b0, last_out: rd_last_reg};

    // input accepts wait out any read in flight, so the two never collide
    assign push      = accept || rd_pending_reg;
    assign push_data = rd_pending_reg ? rd_res : in_res;

    assign issue       = (state_reg == ST_DRAIN) && room;
    assign issue_last  = ((rd_idx_reg + CW'(1)) == drain_total_reg);
    assign mem_rd_en   = issue;
    assign mem_rd_addr = rd_idx_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            bpc_reg         <= BPC_RESET;
            group_accum_reg <= '0;
            group_fill_reg  <= '0;
            extra_count_reg <= '0;
            byte_count_reg  <= '0;
            any_high_reg    <= 1'b0;
            drain_total_reg <= '0;
            rd_idx_reg      <= '0;
            rd_pending_reg  <= 1'b0;
            rd_last_reg     <= 1'b0;
        end
        else
        begin
            rd_pending_reg <= issue;
            if (issue)
            begin
                rd_last_reg <= issue_last;
                rd_idx_reg  <= rd_idx_reg + CW'(1);
                if (issue_last)
                begin
                    state_reg <= ST_IDLE;
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                bpc_reg         <= cfg_data;
                group_accum_reg <= '0;
                group_fill_reg  <= '0;
                extra_count_reg <= '0;
                byte_count_reg  <= '0;
                any_high_reg    <= 1'b0;
            end
            else if (accept)
            begin
                if (in_last)
                begin
                    group_accum_reg <= '0;
                    group_fill_reg  <= '0;
                    extra_count_reg <= '0;
                    byte_count_reg  <= '0;
                    any_high_reg    <= 1'b0;
                    if (drain)
                    begin
                        state_reg       <= ST_DRAIN;
                        drain_total_reg <= ext_new;
                        rd_idx_reg      <= '0;
                    end
                end
                else if (mode_code)
                begin
                    group_accum_reg <= grp_done ? '0 : eff_acc;
                    group_fill_reg  <= grp_done ? '0 : eff_fill;
                    extra_count_reg <= ext_new;
                    byte_count_reg  <= byte_count_reg + CW'(coded);
                    any_high_reg    <= eff_any;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && rd_pending_reg))
        else $error("input accept collides with extra read");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && (fifo_count == OQ_CW'(OQ_DEPTH))))
        else $error("output queue overflow");

    a_drain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (rd_idx_reg < drain_total_reg))
        else $error("drain index beyond stored extras");

    a_extras_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        extra_count_reg <= byte_count_reg)
        else $error("more extras than coded bytes");

    a_read_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |=> rd_pending_reg)
        else $error("extra read lost");
`endif

endmodule : ncp_coder
`default_nettype wire

>>> hdl/narrow_channel_packer.sv
// Top level of the narrow channel packer: coder, extra store and output queue.
// A byte's result is pushed into the output queue in the cycle its request is accepted.
// Throughput: one byte per cycle in a block; a full output queue or a waiting cfg stalls
//   requests. A last byte ending a block with high bits set drains E <= MAX_BLOCK extras,
//   one read per cycle given queue room; new bytes wait until the last read is pushed.
// Reset: rst_n clears the block state and sets bits_per_char to 7; extra store not cleared.
`default_nettype none
module narrow_channel_packer #(
    parameter int MAX_BLOCK = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: bits_per_char
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data,
    // input bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // last_in
    // results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic      [2:0]  m_axis_tuser,   // [1:0] kind, [2] unchanged
    output logic             m_axis_tlast    // last_out
);
    import ncp_pkg::*;

    localparam int AW = $clog2(MAX_BLOCK);
    localparam int CW = $clog2(MAX_BLOCK + 1);

    logic              push;
    ncp_result_t       push_data;
    ncp_result_t       head;
    logic [OQ_CW-1:0]  fifo_count;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [ACC_W-1:0]  mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [ACC_W-1:0]  mem_rd_data;

    // Coder owns all block state; bytes are masked on accept, high bits are grouped
    // and each finished group is written to the extra store at the extras count.
    ncp_coder #(
        .MAX_BLOCK (MAX_BLOCK),
        .AW        (AW),
        .CW        (CW)
    ) u_coder (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_data     (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .fifo_count  (fifo_count),
        .push        (push),
        .push_data   (push_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // Writes happen only on byte accepts and reads only while draining, so one
    // entry is never written and read in the same cycle.
    ncp_extra_mem #(
        .DEPTH (MAX_BLOCK),
        .AW    (AW)
    ) u_extra_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output queue; the coder reserves a slot for every request and read in flight.
    ncp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop_ready (m_axis_tready),
        .pop_valid (m_axis_tvalid),
        .pop_data  (head),
        .count     (fifo_count)
    );

    assign m_axis_tdata = head.out_byte;
    assign m_axis_tuser = {head.unchanged, head.kind};
    assign m_axis_tlast = head.last_out;

endmodule : narrow_channel_packer
`default_nettype wire
